// ----- design/pbam_pkg.sv -----
// Package for the page bank address mapper.
// Region, item kind and page mode codes, plus the fixed offsets.
// No dependencies.
package pbam_pkg;

	localparam int KindW   = 2;
	localparam int AddrW   = 16;
	localparam int ByteW   = 8;
	localparam int RegionW = 3;
	localparam int OffW    = 17;
	localparam int BankW   = 4;
	localparam int NumBank = 8;
	localparam int LowW    = 13;

	localparam logic [KindW-1:0] KIND_READ  = 2'd0;
	localparam logic [KindW-1:0] KIND_WRITE = 2'd1;
	localparam logic [KindW-1:0] KIND_MODE  = 2'd2;

	localparam logic [1:0] MODE_BIOS   = 2'd0;
	localparam logic [1:0] MODE_EXT    = 2'd1;
	localparam logic [1:0] MODE_BANKED = 2'd2;
	localparam logic [1:0] MODE_RAM    = 2'd3;

	localparam logic [1:0] PAGE_0 = 2'd0;
	localparam logic [1:0] PAGE_1 = 2'd1;
	localparam logic [1:0] PAGE_2 = 2'd2;
	localparam logic [1:0] PAGE_3 = 2'd3;

	localparam logic [RegionW-1:0] RG_BIOS   = 3'd0;
	localparam logic [RegionW-1:0] RG_EXT    = 3'd1;
	localparam logic [RegionW-1:0] RG_BANKED = 3'd2;
	localparam logic [RegionW-1:0] RG_CART   = 3'd3;
	localparam logic [RegionW-1:0] RG_RAM    = 3'd4;
	localparam logic [RegionW-1:0] RG_NONE   = 3'd5;

	// 0x18000: upper bits of the fixed bank window
	localparam logic [OffW-LowW-1:0] FIXED_HI = 4'b1100;

endpackage

// ----- design/page_bank_address_mapper.sv -----
// Top level of the page bank address mapper.
// Holds the page mode byte, the bank registers and the two-stage beat pipeline.
// Depends on pbam_pkg.

// Translates one CPU access per clock: a beat taken on the slave side is held in an
// input register, mapped through the page mode byte and bank registers, and then
// registered in the result register, so a beat is accepted every cycle while the
// master side takes results. Mode and bank updates take effect for the next beat.
module page_bank_address_mapper
	import pbam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // region_offset[16:0], ram_data[24:17], zero[31:25]
	output logic [3:0]  m_tuser    // region[2:0], ram_write[3]
);

	logic               valid_s1;
	logic [KindW-1:0]   kind_s1;
	logic [AddrW-1:0]   addr_s1;
	logic [ByteW-1:0]   data_s1;

	logic               valid_s2;
	logic [RegionW-1:0] region_s2;
	logic [OffW-1:0]    off_s2;
	logic               wr_s2;
	logic [ByteW-1:0]   wdata_s2;

	logic [ByteW-1:0]   modes_q;
	logic [BankW-1:0]   bank_q [NumBank];

	logic               adv;
	logic               fire_s1;
	logic [1:0]         page;
	logic               half;
	logic [LowW-1:0]    low;
	logic [1:0]         mode;
	logic [BankW-1:0]   bank_rd;
	logic [2:0]         bank_lo;
	logic [2:0]         bank_hi;
	logic               bank_we;
	logic [RegionW-1:0] region_d;
	logic [OffW-1:0]    off_d;
	logic               wr_d;
	logic [ByteW-1:0]   wdata_d;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire_s1  = valid_s1 && adv;

	assign page    = addr_s1[15:14];
	assign half    = addr_s1[13];
	assign low     = addr_s1[LowW-1:0];
	assign bank_rd = bank_q[{page, half}];
	// mirrored bank write: index & 5, and that OR 2
	assign bank_lo = {page[1], 1'b0, half};
	assign bank_hi = {page[1], 1'b1, half};

	always_comb begin
		unique case (page)
			PAGE_0:  mode = modes_q[1:0];
			PAGE_1:  mode = modes_q[3:2];
			PAGE_2:  mode = modes_q[5:4];
			PAGE_3:  mode = modes_q[7:6];
			default: mode = modes_q[1:0];
		endcase
	end

	always_comb begin
		region_d = RG_NONE;
		off_d    = '0;
		wr_d     = 1'b0;
		wdata_d  = '0;
		bank_we  = 1'b0;
		unique case (kind_s1)
			KIND_READ: begin
				if (mode == MODE_BANKED) begin
					region_d = RG_BANKED;
					off_d    = {bank_rd, low};
				end else begin
					region_d = RG_BANKED;
					off_d    = {FIXED_HI, low};
					unique case (page)
						PAGE_0: begin
							if (mode == MODE_BIOS) begin
								region_d = RG_BIOS;
								off_d    = {3'b000, half, low};
							end else if (mode == MODE_EXT) begin
								region_d = RG_EXT;
								off_d    = {3'b001, half, low};
							end
						end
						PAGE_1: begin
							if (mode == MODE_BIOS) begin
								region_d = RG_BIOS;
								off_d    = {3'b001, half, low};
							end
						end
						PAGE_2: begin
							if (mode == MODE_BIOS) begin
								region_d = RG_CART;
								off_d    = {3'b001, half, low};
							end
						end
						PAGE_3: begin
							if (mode == MODE_RAM) begin
								region_d = RG_RAM;
								off_d    = {3'b000, half, low};
							end
						end
						default: ;
					endcase
				end
			end
			KIND_WRITE: begin
				if (mode == MODE_BANKED) begin
					bank_we = 1'b1;
				end else if (page == PAGE_3 && mode == MODE_RAM) begin
					region_d = RG_RAM;
					off_d    = {3'b000, addr_s1[13:0]};
					wr_d     = 1'b1;
					wdata_d  = data_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			modes_q  <= '0;
			for (int i = 0; i < NumBank; i++) begin
				bank_q[i] <= '0;
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1 && kind_s1 == KIND_MODE) begin
				modes_q <= data_s1;
			end
			if (fire_s1 && bank_we) begin
				bank_q[bank_lo] <= data_s1[BankW-1:0];
				bank_q[bank_hi] <= data_s1[BankW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
		if (fire_s1) begin
			region_s2 <= region_d;
			off_s2    <= off_d;
			wr_s2     <= wr_d;
			wdata_s2  <= wdata_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, wdata_s2, off_s2};
	assign m_tuser  = {wr_s2, region_s2};

`ifndef NO_ASSERTIONS
	a_ram_write_region: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && wr_s2) |-> (region_s2 == RG_RAM && off_s2[OffW-1:14] == '0))
		else $error("ram write outside work ram region");

	a_bank_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q[0] == bank_q[2] && bank_q[1] == bank_q[3] &&
		 bank_q[4] == bank_q[6] && bank_q[5] == bank_q[7]))
		else $error("bank register mirror broken");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");
`endif

endmodule
